### rtl/core/assert_macros.svh
// Assertion macros shared by the vector search core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define BFK_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bfk: property violated");
// expression must never be true outside reset
`define BFK_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("bfk: forbidden condition seen");
`else
`define BFK_ASSERT(name, clk, rst, prop)
`define BFK_NEVER(name, clk, rst, expr)
`endif
`endif

### rtl/core/bfk_pkg.sv
// Shared constants, types and codes of the vector search core
`timescale 1ns / 1ps
`default_nettype none
package bfk_pkg;
   localparam int MAX_DIM     = 128;
   localparam int MAX_VECTORS = 1024;
   localparam int MAX_K       = 16;

   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int ID_W   = $clog2(MAX_VECTORS);
   localparam int CNT_W  = ID_W + 1;
   localparam int K_W    = $clog2(MAX_K + 1);
   localparam int KI_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int ADDR_W = ID_W + DIM_W;

   localparam int ELEM_W   = 16;
   localparam int ECNT_W   = 16;
   localparam int LEN_W    = 8;
   localparam int METRIC_W = 2;
   localparam int RC_W     = 5;
   localparam int STATUS_W = 3;
   localparam int VID_W    = 10;
   localparam int SCORE_W  = 48;
   localparam int RSP_DATA_W = ((VID_W + SCORE_W + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam int MUL_W  = ELEM_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   // sum of squares of MAX_DIM elements
   localparam int SQ_W   = 2 * ELEM_W + DIM_W - 1;
   localparam int NORM_SHIFT = 22;
   localparam int RAD_W  = ((SQ_W + 16 + 1) / 2) * 2;
   localparam int ROOT_W = RAD_W / 2;
   localparam int NUM_W  = ELEM_W + NORM_SHIFT;

   localparam logic [ECNT_W-1:0]  ECNT_CAP  = '1;
   localparam logic [ELEM_W-1:0]  ELEM_SAT  = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [LEN_W-1:0]   VLEN_RESET = LEN_W'(MAX_DIM);
   localparam logic [RC_W-1:0]    RC_RESET  = RC_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESULT_COUNT  = 2'd2;

   localparam logic [METRIC_W-1:0] METRIC_L2     = 2'd0;
   localparam logic [METRIC_W-1:0] METRIC_COSINE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      RSP_MATCH        = 3'd0,
      RSP_INSERTED     = 3'd1,
      RSP_LEN_MISMATCH = 3'd2,
      RSP_FULL         = 3'd3,
      RSP_EMPTY        = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RESP,
      ST_SQ,
      ST_ROOT,
      ST_NRD,
      ST_NDAT,
      ST_NDIV,
      ST_NWR,
      ST_SCAN_START,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       take;
      logic       clr_count;
      logic       sweep_start;
      logic       scan_sel;
      logic       root_start;
      logic       div_start;
      logic       norm_write;
      logic       best_clear;
      logic       best_insert;
      logic       next_vec;
      logic       load_rsp;
      logic       inc_stored;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic len_bad;
      logic op_query;
      logic full;
      logic empty;
      logic cosine;
      logic sweep_done;
      logic zero;
      logic root_done;
      logic div_done;
      logic idx_last;
      logic vec_last;
      logic emit_last;
      logic out_free;
   } stat_type;
endpackage
`default_nettype wire

### rtl/core/bfk_isqrt.sv
// Iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bfk_isqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [bfk_pkg::RAD_W-1:0]  radicand,
   output logic                            busy,
   output logic [bfk_pkg::ROOT_W-1:0]      root
);
   localparam int REM_W = bfk_pkg::ROOT_W + 3;
   localparam int CW    = $clog2(bfk_pkg::ROOT_W + 1);

   logic                        busy_ff, busy_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [bfk_pkg::RAD_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [bfk_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [REM_W-1:0]            rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[bfk_pkg::RAD_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(bfk_pkg::ROOT_W);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[bfk_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[bfk_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

### rtl/core/bfk_div.sv
// Restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bfk_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [bfk_pkg::NUM_W-1:0]  numer,
   input  wire logic [bfk_pkg::ROOT_W-1:0] denom,
   output logic                            busy,
   output logic [bfk_pkg::NUM_W-1:0]       quot
);
   localparam int CW = $clog2(bfk_pkg::NUM_W + 1);

   logic                        busy_ff, busy_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [bfk_pkg::NUM_W-1:0]   quo_ff, quo_in;
   logic [bfk_pkg::ROOT_W-1:0]  rem_ff, rem_in;
   logic [bfk_pkg::ROOT_W-1:0]  den_ff, den_in;
   logic [bfk_pkg::ROOT_W:0]    trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[bfk_pkg::NUM_W-1]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(bfk_pkg::NUM_W);
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = bfk_pkg::ROOT_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[bfk_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[bfk_pkg::ROOT_W-1:0];
            quo_in = {quo_ff[bfk_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;
endmodule
`default_nettype wire

### rtl/core/bfk_dp.sv
// Datapath: buffers, vector store, scoring pipe, normalizer and best list
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bfk_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [bfk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bfk_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_tuser,
   input  wire logic [bfk_pkg::ELEM_W-1:0]     req_tdata,
   input  wire logic                           req_tlast,
   input  wire logic                           rsp_tready,
   output logic                                rsp_tvalid,
   output logic [bfk_pkg::STATUS_W-1:0]        rsp_tuser,
   output logic [bfk_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   input  wire  bfk_pkg::cmd_type              cmd,
   output bfk_pkg::stat_type                   st
);
   // configuration
   logic [bfk_pkg::LEN_W-1:0]    vlen_ff;
   logic [bfk_pkg::METRIC_W-1:0] metric_ff;
   logic [bfk_pkg::RC_W-1:0]     rc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff   <= bfk_pkg::VLEN_RESET;
         metric_ff <= bfk_pkg::METRIC_L2;
         rc_ff     <= bfk_pkg::RC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bfk_pkg::CSR_VECTOR_LENGTH: vlen_ff   <= csr_wdata[bfk_pkg::LEN_W-1:0];
            bfk_pkg::CSR_METRIC_MODE:   metric_ff <= csr_wdata[bfk_pkg::METRIC_W-1:0];
            bfk_pkg::CSR_RESULT_COUNT:  rc_ff     <= csr_wdata[bfk_pkg::RC_W-1:0];
            default: ;
         endcase
      end
   end

   logic cosine, is_l2;
   logic [bfk_pkg::K_W-1:0]   k_eff;
   logic [bfk_pkg::DIM_W-1:0] len_m1;

   always_comb begin
      cosine = (metric_ff == bfk_pkg::METRIC_COSINE);
      is_l2  = (metric_ff == bfk_pkg::METRIC_L2);
      len_m1 = bfk_pkg::DIM_W'(vlen_ff - 1'b1);
      if (rc_ff == '0)
         k_eff = bfk_pkg::K_W'(1);
      else if (int'(rc_ff) > bfk_pkg::MAX_K)
         k_eff = bfk_pkg::K_W'(bfk_pkg::MAX_K);
      else
         k_eff = bfk_pkg::K_W'(rc_ff);
   end

   // element position, store fill and operation kind
   logic [bfk_pkg::ECNT_W-1:0] ecnt_ff;
   logic [bfk_pkg::CNT_W-1:0]  sc_ff;
   logic                       op_query_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ecnt_ff     <= '0;
         sc_ff       <= '0;
         op_query_ff <= 1'b0;
      end else begin
         if (cmd.clr_count)
            ecnt_ff <= '0;
         else if (cmd.take && ecnt_ff != bfk_pkg::ECNT_CAP)
            ecnt_ff <= ecnt_ff + 1'b1;
         if (cmd.take && req_tlast)
            op_query_ff <= req_tuser;
         if (cmd.inc_stored)
            sc_ff <= sc_ff + 1'b1;
      end
   end

   logic pos_ok, store_room;
   assign pos_ok     = (ecnt_ff < bfk_pkg::ECNT_W'(bfk_pkg::MAX_DIM));
   assign store_room = (sc_ff < bfk_pkg::CNT_W'(bfk_pkg::MAX_VECTORS));

   // sweep index and scoring pipe
   logic [bfk_pkg::DIM_W-1:0] idx_ff;
   logic [bfk_pkg::ID_W-1:0]  vec_ff;
   logic                      act_ff, p1_ff, p2_ff;
   logic signed [bfk_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [bfk_pkg::SCORE_W-1:0] acc_ff;

   // memories
   logic [bfk_pkg::ELEM_W-1:0] store_mem [0:bfk_pkg::MAX_VECTORS*bfk_pkg::MAX_DIM-1];
   logic [bfk_pkg::ELEM_W-1:0] qraw_mem  [0:bfk_pkg::MAX_DIM-1];
   logic [bfk_pkg::ELEM_W-1:0] qn_mem    [0:bfk_pkg::MAX_DIM-1];
   logic [bfk_pkg::ELEM_W-1:0] st_rd_ff, qraw_rd_ff, qn_rd_ff;

   logic                       st_we;
   logic [bfk_pkg::ADDR_W-1:0] st_waddr, st_raddr;
   logic [bfk_pkg::ELEM_W-1:0] st_wdata, nval;

   always_comb begin
      if (cmd.norm_write) begin
         st_we    = !op_query_ff;
         st_waddr = {sc_ff[bfk_pkg::ID_W-1:0], idx_ff};
         st_wdata = nval;
      end else begin
         st_we    = cmd.take && !req_tuser && store_room && pos_ok;
         st_waddr = {sc_ff[bfk_pkg::ID_W-1:0], ecnt_ff[bfk_pkg::DIM_W-1:0]};
         st_wdata = req_tdata;
      end
      st_raddr = {(cmd.scan_sel ? vec_ff : sc_ff[bfk_pkg::ID_W-1:0]), idx_ff};
   end

   always_ff @(posedge clock) begin
      if (st_we)
         store_mem[st_waddr] <= st_wdata;
      st_rd_ff <= store_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.take && req_tuser && pos_ok)
         qraw_mem[ecnt_ff[bfk_pkg::DIM_W-1:0]] <= req_tdata;
      qraw_rd_ff <= qraw_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.norm_write && op_query_ff)
         qn_mem[idx_ff] <= nval;
      qn_rd_ff <= qn_mem[idx_ff];
   end

   // operand select: own vector for sum of squares, query against store for scan
   logic signed [bfk_pkg::ELEM_W-1:0] x_src, q_val, v_val;
   logic signed [bfk_pkg::MUL_W-1:0]  mul_a, mul_b, diff;

   always_comb begin
      x_src = op_query_ff ? qraw_rd_ff : st_rd_ff;
      q_val = cosine ? qn_rd_ff : qraw_rd_ff;
      v_val = st_rd_ff;
      diff  = bfk_pkg::MUL_W'(q_val) - bfk_pkg::MUL_W'(v_val);
      if (!cmd.scan_sel) begin
         mul_a = bfk_pkg::MUL_W'(x_src);
         mul_b = bfk_pkg::MUL_W'(x_src);
      end else if (is_l2) begin
         mul_a = diff;
         mul_b = diff;
      end else begin
         mul_a = bfk_pkg::MUL_W'(q_val);
         mul_b = bfk_pkg::MUL_W'(v_val);
      end
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         p1_ff  <= 1'b0;
         p2_ff  <= 1'b0;
         idx_ff <= '0;
         vec_ff <= '0;
      end else begin
         p1_ff <= act_ff;
         p2_ff <= p1_ff;
         if (cmd.sweep_start) begin
            act_ff <= 1'b1;
            idx_ff <= '0;
         end else if (cmd.root_start) begin
            idx_ff <= '0;
         end else if (act_ff) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == len_m1)
               act_ff <= 1'b0;
         end else if (cmd.norm_write) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.best_clear)
            vec_ff <= '0;
         else if (cmd.next_vec)
            vec_ff <= vec_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.sweep_start)
         acc_ff <= '0;
      else if (p2_ff)
         acc_ff <= acc_ff + bfk_pkg::SCORE_W'(prod_ff);
   end

   // normalization: root of the scaled sum of squares, then one divide per element
   logic                        zero_ff;
   logic                        root_busy, div_busy;
   logic [bfk_pkg::ROOT_W-1:0]  root;
   logic [bfk_pkg::NUM_W-1:0]   quot, numer;
   logic [bfk_pkg::ELEM_W:0]    xabs;
   logic                        nsign_ff;
   logic [bfk_pkg::ELEM_W-1:0]  ymag;

   always_comb begin
      xabs  = x_src[bfk_pkg::ELEM_W-1] ? (~{1'b1, x_src} + 1'b1) : {1'b0, x_src};
      numer = (bfk_pkg::NUM_W'(xabs) << bfk_pkg::NORM_SHIFT)
            + bfk_pkg::NUM_W'(root >> 1);
      ymag  = (quot > bfk_pkg::NUM_W'(bfk_pkg::ELEM_SAT)) ? bfk_pkg::ELEM_SAT
            : quot[bfk_pkg::ELEM_W-1:0];
      if (zero_ff)
         nval = '0;
      else
         nval = nsign_ff ? (~ymag + 1'b1) : ymag;
   end

   always_ff @(posedge clock) begin
      if (cmd.root_start)
         zero_ff <= (acc_ff == '0);
      if (cmd.div_start)
         nsign_ff <= x_src[bfk_pkg::ELEM_W-1];
   end

   bfk_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (bfk_pkg::RAD_W'(acc_ff[bfk_pkg::SQ_W-1:0]) << 16),
      .busy     (root_busy),
      .root     (root)
   );

   bfk_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .denom (root),
      .busy  (div_busy),
      .quot  (quot)
   );

   // best list, kept sorted; equal scores stay behind earlier (lower) ids
   logic signed [bfk_pkg::SCORE_W-1:0] best_score_ff [0:bfk_pkg::MAX_K-1];
   logic [bfk_pkg::ID_W-1:0]           best_id_ff    [0:bfk_pkg::MAX_K-1];
   logic [bfk_pkg::K_W-1:0]            fill_ff;
   logic [bfk_pkg::KI_W-1:0]           emit_ff;
   logic signed [bfk_pkg::SCORE_W-1:0] score;
   logic [bfk_pkg::MAX_K-1:0]          keep, prevk;
   logic signed [bfk_pkg::SCORE_W-1:0] ins_score [0:bfk_pkg::MAX_K-1];
   logic [bfk_pkg::ID_W-1:0]           ins_id    [0:bfk_pkg::MAX_K-1];

   always_comb begin
      score = is_l2 ? acc_ff : -acc_ff;
      for (int p = 0; p < bfk_pkg::MAX_K; p++)
         keep[p] = (bfk_pkg::K_W'(p) < fill_ff) && (best_score_ff[p] <= score);
      prevk[0]     = 1'b1;
      ins_score[0] = score;
      ins_id[0]    = vec_ff;
      for (int p = 1; p < bfk_pkg::MAX_K; p++) begin
         prevk[p]     = keep[p-1];
         ins_score[p] = keep[p-1] ? score  : best_score_ff[p-1];
         ins_id[p]    = keep[p-1] ? vec_ff : best_id_ff[p-1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.best_insert) begin
         for (int p = 0; p < bfk_pkg::MAX_K; p++) begin
            if (bfk_pkg::K_W'(p) < k_eff && !keep[p]) begin
               best_score_ff[p] <= ins_score[p];
               best_id_ff[p]    <= ins_id[p];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         emit_ff <= '0;
      end else begin
         if (cmd.best_clear)
            fill_ff <= '0;
         else if (cmd.best_insert && fill_ff < k_eff)
            fill_ff <= fill_ff + 1'b1;
         if (cmd.best_clear)
            emit_ff <= '0;
         else if (cmd.load_rsp && cmd.rsp_status == bfk_pkg::RSP_MATCH)
            emit_ff <= emit_ff + 1'b1;
      end
   end

   // result register
   logic                             rsp_valid_ff;
   bfk_pkg::status_type              rsp_status_ff;
   logic [bfk_pkg::VID_W-1:0]        rsp_id_ff;
   logic [bfk_pkg::SCORE_W-1:0]      rsp_score_ff;
   logic                             rsp_last_ff;
   logic                             out_free, emit_last;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_last = (bfk_pkg::K_W'(emit_ff) + bfk_pkg::K_W'(1) == fill_ff);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.load_rsp)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         if (cmd.rsp_status == bfk_pkg::RSP_MATCH) begin
            rsp_id_ff    <= bfk_pkg::VID_W'(best_id_ff[emit_ff]);
            rsp_score_ff <= cosine ? -best_score_ff[emit_ff] : best_score_ff[emit_ff];
            rsp_last_ff  <= emit_last;
         end else begin
            rsp_id_ff    <= (cmd.rsp_status == bfk_pkg::RSP_INSERTED)
                          ? bfk_pkg::VID_W'(sc_ff) : '0;
            rsp_score_ff <= '0;
            rsp_last_ff  <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = bfk_pkg::RSP_DATA_W'({rsp_score_ff, rsp_id_ff});
   assign rsp_tlast  = rsp_last_ff;

   // status toward the controller
   always_comb begin
      st.len_bad    = (ecnt_ff != bfk_pkg::ECNT_W'(vlen_ff))
                   || (int'(vlen_ff) > bfk_pkg::MAX_DIM);
      st.op_query   = op_query_ff;
      st.full       = !store_room;
      st.empty      = (sc_ff == '0);
      st.cosine     = cosine;
      st.sweep_done = !act_ff && !p1_ff && !p2_ff;
      st.zero       = zero_ff;
      st.root_done  = !root_busy;
      st.div_done   = !div_busy;
      st.idx_last   = (idx_ff == len_m1);
      st.vec_last   = (bfk_pkg::CNT_W'(vec_ff) + bfk_pkg::CNT_W'(1) == sc_ff);
      st.emit_last  = emit_last;
      st.out_free   = out_free;
   end

   `BFK_NEVER(a_store_over, clock, reset, sc_ff > bfk_pkg::CNT_W'(bfk_pkg::MAX_VECTORS))
   `BFK_ASSERT(a_load_free, clock, reset, cmd.load_rsp |-> out_free)
   `BFK_ASSERT(a_div_idle, clock, reset, cmd.div_start |-> !div_busy)
endmodule
`default_nettype wire

### rtl/core/bfk_ctrl.sv
// Controller state machine: element intake, normalization, scan and result sequencing
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bfk_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_tlast,
   output logic                    req_tready,
   input  wire bfk_pkg::stat_type  st,
   output bfk_pkg::cmd_type        cmd
);
   bfk_pkg::state_type  state_ff, state_in;
   bfk_pkg::status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfk_pkg::ST_IDLE;
         code_ff  <= bfk_pkg::RSP_MATCH;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         bfk_pkg::ST_IDLE:
            if (req_tvalid && req_tlast) state_in = bfk_pkg::ST_DECIDE;
         bfk_pkg::ST_DECIDE: begin
            if (st.len_bad) begin
               code_in  = bfk_pkg::RSP_LEN_MISMATCH;
               state_in = bfk_pkg::ST_RESP;
            end else if (!st.op_query) begin
               if (st.full) begin
                  code_in  = bfk_pkg::RSP_FULL;
                  state_in = bfk_pkg::ST_RESP;
               end else if (st.cosine) begin
                  state_in = bfk_pkg::ST_SQ;
               end else begin
                  code_in  = bfk_pkg::RSP_INSERTED;
                  state_in = bfk_pkg::ST_RESP;
               end
            end else begin
               if (st.empty) begin
                  code_in  = bfk_pkg::RSP_EMPTY;
                  state_in = bfk_pkg::ST_RESP;
               end else if (st.cosine) begin
                  state_in = bfk_pkg::ST_SQ;
               end else begin
                  state_in = bfk_pkg::ST_SCAN_START;
               end
            end
         end
         bfk_pkg::ST_RESP:
            if (st.out_free) state_in = bfk_pkg::ST_IDLE;
         bfk_pkg::ST_SQ:
            if (st.sweep_done) state_in = bfk_pkg::ST_ROOT;
         bfk_pkg::ST_ROOT:
            if (st.zero || st.root_done) state_in = bfk_pkg::ST_NRD;
         bfk_pkg::ST_NRD:
            state_in = bfk_pkg::ST_NDAT;
         bfk_pkg::ST_NDAT:
            state_in = st.zero ? bfk_pkg::ST_NWR : bfk_pkg::ST_NDIV;
         bfk_pkg::ST_NDIV:
            if (st.div_done) state_in = bfk_pkg::ST_NWR;
         bfk_pkg::ST_NWR: begin
            if (!st.idx_last) begin
               state_in = bfk_pkg::ST_NRD;
            end else if (st.op_query) begin
               state_in = bfk_pkg::ST_SCAN_START;
            end else begin
               code_in  = bfk_pkg::RSP_INSERTED;
               state_in = bfk_pkg::ST_RESP;
            end
         end
         bfk_pkg::ST_SCAN_START:
            state_in = bfk_pkg::ST_SCAN;
         bfk_pkg::ST_SCAN:
            if (st.sweep_done && st.vec_last) state_in = bfk_pkg::ST_EMIT;
         bfk_pkg::ST_EMIT:
            if (st.out_free && st.emit_last) state_in = bfk_pkg::ST_IDLE;
         default:
            state_in = bfk_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.rsp_status = code_ff;
      req_tready     = 1'b0;
      case (state_ff)
         bfk_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         bfk_pkg::ST_DECIDE: begin
            cmd.clr_count   = 1'b1;
            cmd.sweep_start = !st.len_bad && st.cosine
                            && (st.op_query ? !st.empty : !st.full);
         end
         bfk_pkg::ST_RESP: begin
            cmd.load_rsp   = st.out_free;
            cmd.inc_stored = st.out_free && (code_ff == bfk_pkg::RSP_INSERTED);
         end
         bfk_pkg::ST_SQ:
            cmd.root_start = st.sweep_done;
         bfk_pkg::ST_NDAT:
            cmd.div_start = !st.zero;
         bfk_pkg::ST_NWR:
            cmd.norm_write = 1'b1;
         bfk_pkg::ST_SCAN_START: begin
            cmd.best_clear  = 1'b1;
            cmd.sweep_start = 1'b1;
            cmd.scan_sel    = 1'b1;
         end
         bfk_pkg::ST_SCAN: begin
            cmd.scan_sel    = 1'b1;
            cmd.best_insert = st.sweep_done;
            cmd.next_vec    = st.sweep_done && !st.vec_last;
            cmd.sweep_start = st.sweep_done && !st.vec_last;
         end
         bfk_pkg::ST_EMIT: begin
            cmd.load_rsp   = st.out_free;
            cmd.rsp_status = bfk_pkg::RSP_MATCH;
         end
         default: ;
      endcase
   end

   `BFK_ASSERT(a_decide_on_last, clock, reset, (state_ff == bfk_pkg::ST_DECIDE) |-> $past(req_tvalid && req_tlast))
endmodule
`default_nettype wire

### rtl/core/brute_force_top_k_vector_search_core.sv
// Top level of the brute-force top-k vector search core
// Usage:
//   req_* carries one vector element per beat: tuser is the mode (0 insert,
//   1 query), tdata the Q1.14 element, tlast marks the vector's last element.
//   rsp_* returns results: tuser the status, tdata {score, vector_id} from bit 0
//   up, tlast the final result of the vector that caused them.
//   csr_* writes vector_length (0), metric_mode (1) and result_count (2).
// Timing:
//   Elements are taken one per cycle. After a last element the input stalls
//   until its results are queued. Plain insert and every error status: result
//   is loaded from the RESP state once the output register is free. Cosine
//   normalization adds a sum-of-squares sweep, a root and one divide per element.
//   A query scans the store one element pair per cycle through a single read
//   port, then gives one result per cycle while rsp_tready stays high.
// Reset clears the store fill, element position, best list and sets the
//   registers to 128, 0 and 1. The store itself is not cleared.
// When rsp_tready is low the result beat is held and the sequencer waits;
//   a new vector may start as soon as the last result sits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module brute_force_top_k_vector_search_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [bfk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bfk_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [bfk_pkg::ELEM_W-1:0]     req_tdata,  // element_value
   input  wire logic                           req_tuser,  // mode
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [bfk_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // vector_id, score, zero pad
   output logic [bfk_pkg::STATUS_W-1:0]        rsp_tuser,  // status
   output logic                                rsp_tlast
);
   bfk_pkg::cmd_type  cmd;
   bfk_pkg::stat_type st;

   bfk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bfk_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .st         (st)
   );
endmodule
`default_nettype wire

### tb/brute_force_top_k_vector_search_core_tb.sv
// Self-checking testbench for the brute-force top-k vector search core
`timescale 1ns / 1ps
module brute_force_top_k_vector_search_core_tb;
   import bfk_pkg::*;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;
   localparam logic [METRIC_W-1:0] METRIC_IP     = 2'd1;
   localparam logic [METRIC_W-1:0] METRIC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SEQ_MAX = 140;

   typedef struct {
      status_type           status;
      logic [VID_W-1:0]     id;
      logic [SCORE_W-1:0]   score;
      logic                 last;
   } search_result_t;

   class search_scoreboard;
      shortint vec_mem[MAX_VECTORS][MAX_DIM];
      logic [MAX_DIM-1:0] vec_written[MAX_VECTORS];
      shortint qry_mem[MAX_DIM];
      logic [MAX_DIM-1:0] qry_written;
      shortint unit_vec[MAX_DIM];
      int stored, elem_pos, vec_len, metric, k_reg, errors;
      search_result_t pending[$];

      function new();
         for (int i = 0; i < MAX_VECTORS; i++) vec_written[i] = '0;
         qry_written = '0;
         stored = 0;
         elem_pos = 0;
         vec_len = MAX_DIM;
         metric = 0;
         k_reg = 1;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_VECTOR_LENGTH) vec_len = val;
         else if (idx == CSR_METRIC_MODE) metric = val[1:0];
         else if (idx == CSR_RESULT_COUNT) k_reg = val[4:0];
      endfunction

      function logic [MAX_DIM-1:0] len_mask();
         logic [MAX_DIM-1:0] m;
         m = '0;
         for (int i = 0; i < vec_len && i < MAX_DIM; i++) m[i] = 1'b1;
         return m;
      endfunction

      // true when the planned vector would make the block read a never-written word
      function bit reads_unwritten(logic [SEQ_MAX-1:0] modes, int n);
         logic [MAX_DIM-1:0] qm, sm, need;
         qm = qry_written;
         sm = (stored < MAX_VECTORS) ? vec_written[stored] : '1;
         for (int i = 0; i < n && i < MAX_DIM; i++)
            if (modes[i]) qm[i] = 1'b1; else sm[i] = 1'b1;
         if (n != vec_len || vec_len > MAX_DIM) return 0;
         need = len_mask();
         if (modes[n-1] == MODE_INSERT) return (stored < MAX_VECTORS) && ((sm & need) != need);
         if (stored == 0) return 0;
         if ((qm & need) != need) return 1;
         for (int i = 0; i < stored; i++)
            if ((vec_written[i] & need) != need) return 1;
         return 0;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else
               r = r >> 1;
            b = b >> 2;
         end
         return r;
      endfunction

      // scale a query (slot < 0) or stored vector to unit length, into unit_vec
      function void unit_scale(int slot, int len);
         longint unsigned s, root, a, y;
         longint x;
         s = 0;
         for (int i = 0; i < len; i++) begin
            x = (slot < 0) ? qry_mem[i] : vec_mem[slot][i];
            s += x * x;
         end
         for (int i = 0; i < len; i++) begin
            if (s == 0) begin
               unit_vec[i] = 0;
               continue;
            end
            root = int_sqrt(s << 16);
            x = (slot < 0) ? qry_mem[i] : vec_mem[slot][i];
            a = (x < 0) ? -x : x;
            y = ((a << 22) + root / 2) / root;
            if (y > 32767) y = 32767;
            unit_vec[i] = (x < 0) ? -shortint'(y) : shortint'(y);
         end
      endfunction

      function void expect_beat(status_type st, int id, longint score, bit last);
         search_result_t r;
         r.status = st;
         r.id = id[VID_W-1:0];
         r.score = score[SCORE_W-1:0];
         r.last = last;
         pending.push_back(r);
      endfunction

      function void note_element(logic mode, logic [ELEM_W-1:0] raw, logic last);
         shortint x, q[MAX_DIM];
         longint bs[MAX_K], acc, sc, d;
         int bid[MAX_K], fill, kk, p, cnt, len;
         x = shortint'(raw);
         if (mode == MODE_INSERT) begin
            if (stored < MAX_VECTORS && elem_pos < MAX_DIM) begin
               vec_mem[stored][elem_pos] = x;
               vec_written[stored][elem_pos] = 1'b1;
            end
         end else if (elem_pos < MAX_DIM) begin
            qry_mem[elem_pos] = x;
            qry_written[elem_pos] = 1'b1;
         end
         if (elem_pos < 65535) elem_pos++;
         if (!last) return;
         cnt = elem_pos;
         elem_pos = 0;
         len = vec_len;
         if (cnt != len || len > MAX_DIM) begin
            expect_beat(RSP_LEN_MISMATCH, 0, 0, 1);
            return;
         end
         if (mode == MODE_INSERT) begin
            if (stored >= MAX_VECTORS) begin
               expect_beat(RSP_FULL, 0, 0, 1);
               return;
            end
            if (metric == METRIC_COSINE) begin
               unit_scale(stored, len);
               for (int i = 0; i < len; i++) vec_mem[stored][i] = unit_vec[i];
            end
            expect_beat(RSP_INSERTED, stored, 0, 1);
            stored++;
            return;
         end
         if (stored == 0) begin
            expect_beat(RSP_EMPTY, 0, 0, 1);
            return;
         end
         if (metric == METRIC_COSINE) begin
            unit_scale(-1, len);
            for (int i = 0; i < len; i++) q[i] = unit_vec[i];
         end else
            for (int i = 0; i < len; i++) q[i] = qry_mem[i];
         kk = (k_reg == 0) ? 1 : (k_reg > MAX_K) ? MAX_K : k_reg;
         fill = 0;
         for (int i = 0; i < stored; i++) begin
            acc = 0;
            for (int j = 0; j < len; j++) begin
               if (metric == METRIC_L2) begin
                  d = longint'(q[j]) - longint'(vec_mem[i][j]);
                  acc += d * d;
               end else
                  acc += longint'(q[j]) * longint'(vec_mem[i][j]);
            end
            sc = (metric == METRIC_L2) ? acc : -acc;
            if (fill == kk && sc >= bs[kk-1]) continue;
            p = (fill < kk) ? fill : kk - 1;
            while (p > 0 && bs[p-1] > sc) begin
               bs[p] = bs[p-1];
               bid[p] = bid[p-1];
               p--;
            end
            bs[p] = sc;
            bid[p] = i;
            if (fill < kk) fill++;
         end
         for (int i = 0; i < fill; i++)
            expect_beat(RSP_MATCH, bid[i], (metric == METRIC_COSINE) ? -bs[i] : bs[i],
                        i + 1 == fill);
      endfunction

      function void check_beat(logic [STATUS_W-1:0] st, logic [RSP_DATA_W-1:0] data,
                               logic last);
         search_result_t e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat status %0d data %h", $time, st, data);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
         if (data[VID_W-1:0] !== e.id) begin
            $display("%0t: vector_id expected %0d actual %0d", $time, e.id, data[VID_W-1:0]);
            errors++;
         end
         if (data[VID_W+SCORE_W-1:VID_W] !== e.score) begin
            $display("%0t: score expected %h actual %h", $time, e.score,
                     data[VID_W+SCORE_W-1:VID_W]);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic req_tvalid, req_tready, req_tuser, req_tlast;
   logic [ELEM_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tlast;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;

   search_scoreboard sb;
   int cycles, hold;
   bit gaps_on, stalls_on;
   logic [SEQ_MAX-1:0] seq_mode;
   logic [ELEM_W-1:0] seq_val[SEQ_MAX];
   int seq_len;

   brute_force_top_k_vector_search_core dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // result side: check each beat, random backpressure with occasional long stalls
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("brute_force_top_k_vector_search_core verification failed");
         $finish;
      end else begin
         if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tuser, rsp_tdata, rsp_tlast);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 99) < 3) begin
            hold = $urandom_range(5, 40);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !stalls_on || ($urandom_range(0, 99) < 75);
         end
      end
   end

   function logic [ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return '0;
         3, 4: return ELEM_W'($urandom_range(0, 128) - 64);
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   task send_element(logic mode, logic [ELEM_W-1:0] val, logic last);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= val;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_element(mode, val, last);
      if (gaps_on && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 19) == 0) repeat ($urandom_range(10, 60)) @(posedge clock);
         else repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task send_sequence();
      for (int i = 0; i < seq_len; i++)
         send_element(seq_mode[i], seq_val[i], i == seq_len - 1);
   endtask

   task send_uniform(logic mode, int n);
      seq_len = n;
      for (int i = 0; i < n; i++) begin
         seq_mode[i] = mode;
         seq_val[i] = pick_value();
      end
      send_sequence();
   endtask

   // mostly well-formed vectors; some with a wrong count, some with mixed modes
   task send_random_vector(int len);
      int kind;
      logic m;
      kind = $urandom_range(0, 99);
      m = ($urandom_range(0, 99) < 55) ? MODE_INSERT : MODE_QUERY;
      seq_len = len;
      if (kind < 15) begin
         seq_len = ($urandom_range(0, 1) && len > 1) ? len - $urandom_range(1, (len > 3) ? 3 : len - 1)
                                                      : len + $urandom_range(1, 3);
      end
      for (int i = 0; i < seq_len; i++) begin
         seq_mode[i] = (kind >= 85) ? logic'($urandom_range(0, 1)) : m;
         seq_val[i] = pick_value();
      end
      if (sb.reads_unwritten(seq_mode, seq_len))
         for (int i = 0; i < seq_len; i++) seq_mode[i] = seq_mode[seq_len-1];
      send_sequence();
   endtask

   task wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task set_regs(int len, logic [METRIC_W-1:0] met, int k);
      write_reg(CSR_VECTOR_LENGTH, len);
      write_reg(CSR_METRIC_MODE, met);
      write_reg(CSR_RESULT_COUNT, k);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task run_phase(int len, logic [METRIC_W-1:0] met, int k, int nvec);
      set_regs(len, met, k);
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < nvec; i++) send_random_vector(len);
      wait_drained();
   endtask

   initial begin
      sb = new();
      cycles = 0;
      hold = 0;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: full-length vectors, empty store first
      send_uniform(MODE_QUERY, MAX_DIM);
      send_uniform(MODE_INSERT, 5);
      for (int i = 0; i < 3; i++) send_uniform(MODE_INSERT, MAX_DIM);
      send_uniform(MODE_QUERY, MAX_DIM);
      send_uniform(MODE_QUERY, MAX_DIM + 2);
      wait_drained();

      // directed: extremes, zero vector, wrong counts, mixed modes
      set_regs(4, METRIC_L2, 3);
      seq_len = 4;
      seq_mode = '0;
      seq_val[0] = 16'h7FFF; seq_val[1] = 16'h8000; seq_val[2] = 16'h0000; seq_val[3] = 16'h1000;
      send_sequence();
      seq_val[0] = 16'h8000; seq_val[1] = 16'h7FFF; seq_val[2] = 16'hFFFF; seq_val[3] = 16'h0001;
      send_sequence();
      for (int i = 0; i < 4; i++) seq_val[i] = '0;
      send_sequence();
      seq_mode = '1;
      seq_val[0] = 16'h8000; seq_val[1] = 16'h8000; seq_val[2] = 16'h7FFF; seq_val[3] = 16'h7FFF;
      send_sequence();
      send_uniform(MODE_INSERT, 3);
      send_uniform(MODE_QUERY, 5);
      seq_len = 4;
      seq_mode = '0;
      seq_mode[1] = MODE_QUERY;
      seq_mode[3] = MODE_QUERY;
      send_sequence();
      wait_drained();

      run_phase(4, METRIC_IP, 16, 20);
      run_phase(4, METRIC_COSINE, 5, 20);
      run_phase(4, METRIC_UNUSED, 0, 15);
      run_phase(3, METRIC_L2, 31, 20);
      run_phase(2, METRIC_COSINE, 16, 20);
      run_phase(1, METRIC_IP, 2, 20);

      // fill the store, then hit the full case
      set_regs(1, METRIC_L2, 16);
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      while (sb.stored < MAX_VECTORS) send_uniform(MODE_INSERT, 1);
      send_uniform(MODE_INSERT, 1);
      send_uniform(MODE_INSERT, 2);
      send_uniform(MODE_INSERT, 1);
      send_uniform(MODE_QUERY, 1);
      wait_drained();
      set_regs(1, METRIC_COSINE, 16);
      stalls_on = 1'b1;
      send_uniform(MODE_QUERY, 1);
      wait_drained();

      if (sb.errors == 0)
         $display("brute_force_top_k_vector_search_core verification clean");
      else
         $display("brute_force_top_k_vector_search_core verification failed");
      $finish;
   end
endmodule
